FILE: rtl/core/pump_speed_ramp_controller_assert.svh
// Assertion macros for the pump speed ramp controller
`ifndef PUMP_SPEED_RAMP_CONTROLLER_ASSERT_SVH
`define PUMP_SPEED_RAMP_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/psrc_pkg.sv
// Types and constants shared by the pump speed ramp controller modules
package psrc_pkg;

  localparam int SAMPLE_W = 16;
  localparam logic [SAMPLE_W-1:0] POT_MASK = 16'hFFFE;
  localparam logic [SAMPLE_W-1:0] POT_LOW  = 16'd10;
  localparam logic [SAMPLE_W-1:0] POT_HIGH = 16'd1020;
  localparam int POT_OFF_W = 10;
  localparam int POT_SPAN  = 1010;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FREQ_W     = 23;
  localparam int WEIGHT_W   = 16;
  localparam int SMOOTH_W   = 24;
  localparam int PERIOD_W   = 32;
  localparam int TENTHS_W   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 2'd3;

  localparam logic [CFG_DATA_W-1:0] RST_CLOCK_HZ = 32'd84000000;
  localparam logic [FREQ_W-1:0]     RST_MIN_FREQ = 23'd546133;
  localparam logic [FREQ_W-1:0]     RST_MAX_FREQ = 23'd5461333;
  localparam logic [WEIGHT_W-1:0]   RST_WEIGHT   = 16'd1638;

  // shared multiplier
  localparam int MUL_A_W = 16;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // filter accumulator
  localparam int ACC_W     = 42;
  localparam int ROUND_SH  = 16;

  // shared divider
  localparam int DIV_DW    = 24;
  localparam int DIV_QW    = 32;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] MAP_STEPS = 6'd23;
  localparam logic [DIV_CNT_W-1:0] PER_STEPS = 6'd32;

  // display scaling: target * 3 / (128 << frac)
  localparam int TENTHS_SH_BASE = 7;
  localparam int TENTHS_MAG_W   = 25;
  localparam logic [TENTHS_MAG_W-1:0] TENTHS_POS_MAX = 25'd511;
  localparam logic [TENTHS_MAG_W-1:0] TENTHS_NEG_MAX = 25'd512;
  localparam logic [TENTHS_W-1:0] TENTHS_POS_SAT = 10'h1FF;
  localparam logic [TENTHS_W-1:0] TENTHS_NEG_SAT = 10'h200;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_DIV,
    ST_MAP_WAIT,
    ST_TGT,
    ST_SNAP,
    ST_FILT_MUL,
    ST_FILT_ADD,
    ST_FILT_RND,
    ST_PER_CHK,
    ST_PER_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/pump_speed_ramp_controller.sv
// Pump speed ramp controller: pot map, speed smoothing filter and PWM period sequencer
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | pot_sample, switch_one, switch_two
//   out     | output    | out_valid/out_stall | period, high time, disable, dir, tenths
//   cfg     | input     | cfg_we              | cfg_addr, cfg_wdata
//
// An item runs the pot map divide, the filter and, unless the period saturates, the
// period divide on the shared radix-2 divider (23 steps for the map, 32 for the
// period). in_stall stays high until the result is loaded into the output register,
// which holds under out_stall while the next item is taken. Reset restores the
// register defaults and sets the smoothed frequency to +min.
`include "pump_speed_ramp_controller_assert.svh"

module pump_speed_ramp_controller import psrc_pkg::*; #(
  parameter int POT_BITS       = 10,
  parameter int FREQ_FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [POT_BITS-1:0]        in_pot_sample,
  input  logic                       in_switch_one,
  input  logic                       in_switch_two,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [PERIOD_W-1:0]        out_period_cycles,
  output logic [PERIOD_W-2:0]        out_high_cycles,
  output logic                       out_disable_drive,
  output logic                       out_reverse_dir,
  output logic signed [TENTHS_W-1:0] out_display_tenths,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_addr,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] clock_hz_r;
  logic [FREQ_W-1:0]     min_freq_r;
  logic [FREQ_W-1:0]     max_freq_r;
  logic [WEIGHT_W-1:0]   weight_r;

  logic signed [SMOOTH_W-1:0] smoothed_r;

  logic [POT_OFF_W-1:0]  soff_r;
  logic                  off_r;
  logic                  rev_r;
  logic                  span_neg_r;
  logic [MUL_P_W-1:0]    prod_r;
  logic [FREQ_W-1:0]     tmag_r;
  logic signed [SMOOTH_W-1:0] cur_r;
  logic                  dneg_r;
  logic [MUL_B_W-1:0]    dmag_r;
  logic [ACC_W-2:0]      nmag_r;
  logic                  nneg_r;
  logic [SMOOTH_W-1:0]   smag_r;
  logic                  sneg_r;
  logic [PERIOD_W-1:0]   period_r;
  logic signed [TENTHS_W-1:0] tenths_r;

  logic                  out_valid_r;
  logic [PERIOD_W-1:0]   out_period_r;
  logic                  out_disable_r;
  logic                  out_reverse_r;
  logic signed [TENTHS_W-1:0] out_tenths_r;

  logic                  in_xfer;
  logic                  out_load;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [DIV_QW-1:0]     div_quo;
  logic [DIV_CNT_W-1:0]  div_steps;
  logic [DIV_DW-1:0]     div_rem_init;
  logic [DIV_QW-1:0]     div_quo_init;
  logic [DIV_DW-1:0]     div_divisor;

  // input conditioning
  logic [SAMPLE_W-1:0]   s_ext;
  logic [SAMPLE_W-1:0]   s_cl;
  logic [SAMPLE_W-1:0]   s_off;

  // span and shared multiplier
  logic                  span_neg;
  logic [FREQ_W-1:0]     span_mag;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    mul_p;

  // target
  logic [FREQ_W-1:0]     map_q;
  logic [FREQ_W-1:0]     tmag_nxt;

  // snapping
  logic signed [SMOOTH_W-1:0] tm_s;
  logic signed [SMOOTH_W-1:0] min_s;
  logic signed [SMOOTH_W-1:0] goal_t;
  logic signed [SMOOTH_W-1:0] goal;
  logic signed [SMOOTH_W-1:0] cur;
  logic signed [MUL_B_W-1:0]  goal_x;
  logic signed [MUL_B_W-1:0]  cur_x;
  logic signed [MUL_B_W-1:0]  d_a;
  logic signed [MUL_B_W-1:0]  d_b;

  // filter
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] sp;
  logic signed [ACC_W-1:0] acc_a;
  logic signed [ACC_W-1:0] acc_b;
  logic [ACC_W-2:0]        rnd;

  // period
  logic [DIV_DW-1:0]     per_hi;
  logic [PERIOD_W-1:0]   per_lo;
  logic                  per_sat;

  // display
  logic [TENTHS_MAG_W-1:0] m3;
  logic [TENTHS_MAG_W-1:0] tq;
  logic [TENTHS_W-1:0]     tenths_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= RST_CLOCK_HZ;
      min_freq_r <= RST_MIN_FREQ;
      max_freq_r <= RST_MAX_FREQ;
      weight_r   <= RST_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CLOCK_HZ: clock_hz_r <= cfg_wdata;
        REG_MIN_FREQ: min_freq_r <= cfg_wdata[FREQ_W-1:0];
        REG_MAX_FREQ: max_freq_r <= cfg_wdata[FREQ_W-1:0];
        REG_WEIGHT:   weight_r   <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath combinational terms
  always_comb begin
    s_ext = SAMPLE_W'(in_pot_sample) & POT_MASK;
    if (s_ext < POT_LOW) begin
      s_cl = POT_LOW;
    end else if (s_ext > POT_HIGH) begin
      s_cl = POT_HIGH;
    end else begin
      s_cl = s_ext;
    end
    s_off = s_cl - POT_LOW;

    span_neg = (max_freq_r > min_freq_r);
    span_mag = span_neg ? (max_freq_r - min_freq_r) : (min_freq_r - max_freq_r);

    if (state_r == ST_FILT_MUL) begin
      mul_a = weight_r;
      mul_b = dmag_r;
    end else begin
      mul_a = MUL_A_W'(soff_r);
      mul_b = MUL_B_W'(span_mag);
    end
    mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    map_q    = div_quo[FREQ_W-1:0];
    tmag_nxt = span_neg_r ? (max_freq_r - map_q) : (max_freq_r + map_q);

    tm_s   = $signed({1'b0, tmag_r});
    min_s  = $signed({1'b0, min_freq_r});
    goal_t = rev_r ? -tm_s : tm_s;
    if ((tmag_r == '0) || (!rev_r && smoothed_r[SMOOTH_W-1])) begin
      goal = min_s;
      cur  = min_s;
    end else if (rev_r && !smoothed_r[SMOOTH_W-1] && (smoothed_r != '0)) begin
      goal = -min_s;
      cur  = -min_s;
    end else begin
      goal = goal_t;
      cur  = smoothed_r;
    end
    goal_x = MUL_B_W'(goal);
    cur_x  = MUL_B_W'(cur);
    d_a    = goal_x - cur_x;
    d_b    = cur_x - goal_x;

    base  = ACC_W'(cur_r) <<< ROUND_SH;
    sp    = $signed({1'b0, prod_r});
    acc_a = dneg_r ? (base - sp) : (base + sp);
    acc_b = dneg_r ? (sp - base) : (-base - sp);
    rnd   = nmag_r + (ACC_W-1)'(1 << (ROUND_SH - 1));

    per_hi  = DIV_DW'(clock_hz_r >> (PERIOD_W - FREQ_FRAC_BITS));
    per_lo  = clock_hz_r << FREQ_FRAC_BITS;
    per_sat = (per_hi >= smag_r);

    m3 = TENTHS_MAG_W'({tmag_r, 1'b0}) + TENTHS_MAG_W'(tmag_r);
    tq = m3 >> (TENTHS_SH_BASE + FREQ_FRAC_BITS);
    if (rev_r) begin
      tenths_nxt = (tq > TENTHS_NEG_MAX) ? TENTHS_NEG_SAT : (TENTHS_W'(0) - tq[TENTHS_W-1:0]);
    end else begin
      tenths_nxt = (tq > TENTHS_POS_MAX) ? TENTHS_POS_SAT : tq[TENTHS_W-1:0];
    end
  end

  // divider operand select
  always_comb begin
    if (state_r == ST_MAP_DIV) begin
      div_steps    = MAP_STEPS;
      div_rem_init = DIV_DW'(prod_r[32:23]);
      div_quo_init = {prod_r[22:0], 9'b0};
      div_divisor  = DIV_DW'(POT_SPAN);
    end else begin
      div_steps    = PER_STEPS;
      div_rem_init = per_hi;
      div_quo_init = per_lo;
      div_divisor  = smag_r;
    end
  end

  psrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .quo_init (div_quo_init),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_MAP_MUL;
      end
      ST_MAP_MUL:  state_nxt = ST_MAP_DIV;
      ST_MAP_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_MAP_WAIT;
      end
      ST_MAP_WAIT: begin
        if (div_stat.done) state_nxt = ST_TGT;
      end
      ST_TGT:      state_nxt = ST_SNAP;
      ST_SNAP:     state_nxt = ST_FILT_MUL;
      ST_FILT_MUL: state_nxt = ST_FILT_ADD;
      ST_FILT_ADD: state_nxt = ST_FILT_RND;
      ST_FILT_RND: state_nxt = ST_PER_CHK;
      ST_PER_CHK: begin
        if (per_sat) begin
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_PER_WAIT;
        end
      end
      ST_PER_WAIT: begin
        if (div_stat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // smoothed frequency state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= $signed({1'b0, RST_MIN_FREQ});
    end else if (state_r == ST_PER_CHK) begin
      smoothed_r <= sneg_r ? $signed(SMOOTH_W'(0) - smag_r) : $signed(smag_r);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          soff_r <= s_off[POT_OFF_W-1:0];
          off_r  <= !in_switch_one && in_switch_two;
          rev_r  <= !in_switch_one && !in_switch_two;
        end
      end
      ST_MAP_MUL: begin
        prod_r     <= mul_p;
        span_neg_r <= span_neg;
      end
      ST_TGT: begin
        tmag_r <= off_r ? '0 : tmag_nxt;
      end
      ST_SNAP: begin
        cur_r    <= cur;
        dneg_r   <= d_a[MUL_B_W-1];
        dmag_r   <= d_a[MUL_B_W-1] ? d_b : d_a;
        tenths_r <= $signed(tenths_nxt);
      end
      ST_FILT_MUL: begin
        prod_r <= mul_p;
      end
      ST_FILT_ADD: begin
        nneg_r <= acc_a[ACC_W-1];
        nmag_r <= acc_a[ACC_W-1] ? acc_b[ACC_W-2:0] : acc_a[ACC_W-2:0];
      end
      ST_FILT_RND: begin
        smag_r <= rnd[ROUND_SH+SMOOTH_W-1:ROUND_SH];
        sneg_r <= nneg_r;
      end
      ST_PER_CHK: begin
        if (per_sat) period_r <= '1;
      end
      ST_PER_WAIT: begin
        if (div_stat.done) period_r <= div_quo;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_period_r  <= period_r;
      out_disable_r <= off_r;
      out_reverse_r <= rev_r;
      out_tenths_r  <= tenths_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_period_cycles  = out_period_r;
  assign out_high_cycles    = out_period_r[PERIOD_W-1:1];
  assign out_disable_drive  = out_disable_r;
  assign out_reverse_dir    = out_reverse_r;
  assign out_display_tenths = out_tenths_r;

  `PSRC_ASSERT_NOW(a_div_done_waiting, div_stat.done, state_r == ST_MAP_WAIT || state_r == ST_PER_WAIT, "divider finished outside a wait state")
  `PSRC_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divider restarted while busy")
  `PSRC_ASSERT_NEXT(a_div_start_busy, div_start, div_stat.busy, "divider did not start")
  `PSRC_ASSERT_NOW(a_mode_exclusive, out_valid, !(out_disable_drive && out_reverse_dir), "off and reverse both set")

endmodule

FILE: rtl/core/psrc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by the map and the period
module psrc_div import psrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_CNT_W-1:0] steps,
  input  logic [DIV_DW-1:0]    rem_init,
  input  logic [DIV_QW-1:0]    quo_init,
  input  logic [DIV_DW-1:0]    divisor,
  output div_stat_t            stat,
  output logic [DIV_QW-1:0]    quotient
);

  logic [DIV_DW-1:0]    rem_r;
  logic [DIV_QW-1:0]    quo_r;
  logic [DIV_DW-1:0]    div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;

  logic [DIV_DW:0]      trial;
  logic [DIV_DW+1:0]    diff;
  logic                 ge;
  logic [DIV_DW-1:0]    rem_nxt;
  logic [DIV_QW-1:0]    quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIV_QW-1]};
    diff    = {1'b0, trial} - {2'b00, div_r};
    ge      = ~diff[DIV_DW+1];
    rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    quo_nxt = {quo_r[DIV_QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - 1'b1;
      done_r <= (cnt_r == DIV_CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      quo_r <= quo_init;
      div_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the pump speed ramp controller: directed, extreme-setting and random runs
`timescale 1ns / 100ps

module tb_top;
  import psrc_pkg::*;

  localparam int POT_W = 10;
  localparam int FREQ_FRAC = 8;
  localparam longint SAMPLE_LOW = 10;
  localparam longint SAMPLE_HIGH = 1020;
  localparam longint SAMPLE_SPAN = 1010;
  localparam longint WEIGHT_ONE = 65536;
  localparam longint ROUND_HALF = 32768;
  localparam longint TENTHS_DIV = 128 << FREQ_FRAC;
  localparam longint TENTHS_MAX = 511;
  localparam longint TENTHS_MIN = -512;
  localparam longint PERIOD_SAT = 64'h0000_0000_FFFF_FFFF;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 45;

  typedef struct {
    logic [PERIOD_W-1:0]        period;
    logic [PERIOD_W-2:0]        high;
    logic                       drive_off;
    logic                       reverse;
    logic signed [TENTHS_W-1:0] tenths;
  } pwm_setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POT_W-1:0] in_pot_sample = '0;
  logic in_switch_one = 1'b1;
  logic in_switch_two = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PERIOD_W-1:0] out_period_cycles;
  logic [PERIOD_W-2:0] out_high_cycles;
  logic out_disable_drive;
  logic out_reverse_dir;
  logic signed [TENTHS_W-1:0] out_display_tenths;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and the smoothed frequency
  logic [CFG_DATA_W-1:0] clock_hz = RST_CLOCK_HZ;
  logic [FREQ_W-1:0] min_q8 = RST_MIN_FREQ;
  logic [FREQ_W-1:0] max_q8 = RST_MAX_FREQ;
  logic [WEIGHT_W-1:0] weight_q16 = RST_WEIGHT;
  logic signed [SMOOTH_W-1:0] ramp_freq = RST_MIN_FREQ;

  pwm_setting_t pwm_queue[$];
  pwm_setting_t want;
  logic [1:0] run_switches = 2'b11;
  logic tx_idle_en = 1'b1;
  logic rx_idle_en = 1'b1;
  logic hold_off_req = 1'b0;
  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;

  pump_speed_ramp_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pot_sample     (in_pot_sample),
    .in_switch_one     (in_switch_one),
    .in_switch_two     (in_switch_two),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_period_cycles (out_period_cycles),
    .out_high_cycles   (out_high_cycles),
    .out_disable_drive (out_disable_drive),
    .out_reverse_dir   (out_reverse_dir),
    .out_display_tenths(out_display_tenths),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic pwm_setting_t advance_ramp(logic [POT_W-1:0] pot, logic sw_one,
                                                logic sw_two);
    longint s, span, target, goal, cur, w, num, mag, per, tenths;
    logic off_mode, rev_mode;
    pwm_setting_t r;
    s = longint'({pot[POT_W-1:1], 1'b0});
    if (s < SAMPLE_LOW) s = SAMPLE_LOW;
    if (s > SAMPLE_HIGH) s = SAMPLE_HIGH;
    span = longint'(min_q8) - longint'(max_q8);
    target = longint'(max_q8) + ((s - SAMPLE_LOW) * span) / SAMPLE_SPAN;
    off_mode = !sw_one && sw_two;
    rev_mode = !sw_one && !sw_two;
    if (off_mode) target = 0;
    if (rev_mode) target = -target;
    goal = target;
    cur = longint'(ramp_freq);
    if (goal == 0 || (goal > 0 && cur < 0)) begin
      goal = longint'(min_q8);
      cur = goal;
    end
    if (goal < 0 && cur > 0) begin
      goal = -longint'(min_q8);
      cur = goal;
    end
    w = longint'(weight_q16);
    num = (WEIGHT_ONE - w) * cur + w * goal;
    if (num >= 0) cur = (num + ROUND_HALF) >>> 16;
    else cur = -((-num + ROUND_HALF) >>> 16);
    ramp_freq = cur[SMOOTH_W-1:0];
    mag = (cur < 0) ? -cur : cur;
    if (mag == 0) begin
      per = PERIOD_SAT;
    end else begin
      per = (longint'(clock_hz) << FREQ_FRAC) / mag;
      if (per > PERIOD_SAT) per = PERIOD_SAT;
    end
    tenths = (target * 3) / TENTHS_DIV;
    if (tenths > TENTHS_MAX) tenths = TENTHS_MAX;
    if (tenths < TENTHS_MIN) tenths = TENTHS_MIN;
    r.period = per[PERIOD_W-1:0];
    r.high = per[PERIOD_W-1:1];
    r.drive_off = off_mode;
    r.reverse = rev_mode;
    r.tenths = tenths[TENTHS_W-1:0];
    return r;
  endfunction

  task automatic check_field(string field, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pwm_queue.size() == 0) begin
        $error("result transfer with no expected PWM setting");
        fail_count++;
      end else begin
        want = pwm_queue.pop_front();
        results_seen++;
        check_field("period_cycles", want.period, out_period_cycles);
        check_field("high_cycles", want.high, out_high_cycles);
        check_field("disable_drive", want.drive_off, out_disable_drive);
        check_field("reverse_dir", want.reverse, out_reverse_dir);
        check_field("display_tenths", want.tenths, out_display_tenths);
      end
    end
  end

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_stall = rx_idle_en && ($urandom_range(99) < 13);
      end
    end
  end

  task automatic send_item(logic [POT_W-1:0] pot, logic sw_one, logic sw_two);
    int gap;
    @(negedge clk);
    if (tx_idle_en && $urandom_range(99) < 13) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(70, 4) : $urandom_range(3, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pot_sample = pot;
    in_switch_one = sw_one;
    in_switch_two = sw_two;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pwm_queue.push_back(advance_ramp(pot, sw_one, sw_two));
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pwm_queue.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CLOCK_HZ: clock_hz = data;
      REG_MIN_FREQ: min_q8 = data[FREQ_W-1:0];
      REG_MAX_FREQ: max_q8 = data[FREQ_W-1:0];
      REG_WEIGHT:   weight_q16 = data[WEIGHT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_setting(logic [31:0] clk_v, logic [FREQ_W-1:0] min_v,
                              logic [FREQ_W-1:0] max_v, logic [WEIGHT_W-1:0] w_v);
    drain_results();
    write_reg(REG_CLOCK_HZ, clk_v);
    write_reg(REG_MIN_FREQ, {9'($urandom), min_v});
    write_reg(REG_MAX_FREQ, {9'($urandom), max_v});
    write_reg(REG_WEIGHT, {16'($urandom), w_v});
  endtask

  task automatic run_random_items(int count);
    logic [POT_W-1:0] pot;
    repeat (count) begin
      if ($urandom_range(99) < 15) run_switches = 2'($urandom_range(3));
      if ($urandom_range(7) == 0)
        pot = $urandom_range(1) ? POT_W'($urandom_range(12)) : POT_W'($urandom_range(1023, 1018));
      else
        pot = POT_W'($urandom_range(1023));
      send_item(pot, run_switches[1], run_switches[0]);
    end
  endtask

  task automatic test_default_mapping();
    send_item(10'd0, 1'b1, 1'b1);
    send_item(10'd1023, 1'b1, 1'b1);
    send_item(10'd11, 1'b1, 1'b0);
    send_item(10'd1021, 1'b1, 1'b1);
    send_item(10'd512, 1'b1, 1'b0);
    send_item(10'd300, 1'b0, 1'b0);
    send_item(10'd700, 1'b0, 1'b0);
    send_item(10'd500, 1'b0, 1'b1);
    send_item(10'd400, 1'b1, 1'b1);
    send_item(10'd900, 1'b0, 1'b0);
    send_item(10'd600, 1'b1, 1'b0);
  endtask

  task automatic test_register_extremes();
    // slowest minimum and fastest maximum with the widest clock: period and display saturate
    load_setting('1, 23'd1, 23'h7FFFFF, 16'hFFFF);
    send_item(10'd0, 1'b1, 1'b1);
    send_item(10'd0, 1'b0, 1'b0);
    send_item(10'd1023, 1'b0, 1'b1);
    send_item(10'd1023, 1'b1, 1'b1);
    // minimum above maximum, frozen filter
    load_setting(32'd1, 23'h7FFFFF, 23'd1, 16'd0);
    send_item(10'd0, 1'b1, 1'b1);
    send_item(10'd1023, 1'b1, 1'b1);
    send_item(10'd512, 1'b0, 1'b0);
    // minimum of zero: smoothed frequency reaches zero
    load_setting(RST_CLOCK_HZ, 23'd0, RST_MAX_FREQ, 16'd32768);
    send_item(10'd1023, 1'b1, 1'b1);
    send_item(10'd500, 1'b0, 1'b1);
  endtask

  task automatic test_random_settings();
    logic [31:0] clk_v;
    logic [WEIGHT_W-1:0] w_v;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(5))
        0: clk_v = 32'd1;
        1: clk_v = '1;
        default: clk_v = $urandom;
      endcase
      case ($urandom_range(7))
        0: w_v = '0;
        1: w_v = '1;
        default: w_v = WEIGHT_W'($urandom);
      endcase
      load_setting(clk_v, FREQ_W'($urandom_range(8388607, 1)),
                   FREQ_W'($urandom_range(8388607, 1)), w_v);
      tx_idle_en = (phase != 3);
      rx_idle_en = (phase != 3);
      run_random_items(ITEMS_PER_PHASE);
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_hold_off();
    drain_results();
    hold_off_req = 1'b1;
    run_random_items(12);
  endtask

  task automatic test_sender_pause();
    load_setting(RST_CLOCK_HZ, RST_MIN_FREQ, RST_MAX_FREQ, RST_WEIGHT);
    run_random_items(10);
    drain_results();
    run_random_items(10);
  endtask

  initial begin : timeout
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_default_mapping();
    test_register_extremes();
    test_random_settings();
    test_output_hold_off();
    test_sender_pause();
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d sample transfers and %0d checked results across %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("Included clamp edges, all switch modes, saturation cases, output hold-off and drains.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/psrc_pkg.sv
rtl/core/psrc_div.sv
rtl/core/pump_speed_ramp_controller.sv
tb/tb_top.sv
